// File: rtl/idet_pkg.sv
// ----------------------------------------------------------------------------
// idet_pkg
// shared types, widths and the micro-op program of the 4x4 determinant core
// ----------------------------------------------------------------------------
package idet_pkg;

    localparam int MAX_ORDER  = 4;
    localparam int CELLS      = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);
    localparam int ORDER_W    = 3;
    localparam int ENTRY_W    = 15;
    localparam int SCR_W      = 47;   // widest 3x3 minor
    localparam int DET_W      = 62;
    localparam int SCR_DEPTH  = 10;   // six 2x2 minors, four 3x3 minors
    localparam int SCR_AW     = $clog2(SCR_DEPTH);
    localparam int PROG_LEN   = 40;
    localparam int PC_W       = $clog2(PROG_LEN);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    typedef enum logic {
        UK_LOAD,    // latch the fetched entry as the second operand
        UK_MAC      // multiply fetched entry by operand, add or subtract
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [1:0]        row;
        logic [1:0]        col;
        logic              use_tmp;
        logic [SCR_AW-1:0] src;
        logic              neg;
        logic              last;
        logic [SCR_AW-1:0] dst;
    } t_uop;

    typedef struct packed {
        logic               ld_en;
        logic [ADDR_W-1:0]  ld_addr;
        logic               fetch;
        logic               exec;
        logic               accum;
        logic               clr;
        logic [ORDER_W-1:0] order;
        t_uop               uop;
    } t_dp_cmd;

    function automatic t_uop ld(input logic [1:0] r, input logic [1:0] c);
        t_uop u;
        u.kind    = UK_LOAD;
        u.row     = r;
        u.col     = c;
        u.use_tmp = 1'b1;
        u.src     = '0;
        u.neg     = 1'b0;
        u.last    = 1'b0;
        u.dst     = '0;
        return u;
    endfunction

    function automatic t_uop mac(input logic [1:0] r, input logic [1:0] c,
                                 input logic tmp, input logic [SCR_AW-1:0] s,
                                 input logic ng, input logic lst,
                                 input logic [SCR_AW-1:0] d);
        t_uop u;
        u.kind    = UK_MAC;
        u.row     = r;
        u.col     = c;
        u.use_tmp = tmp;
        u.src     = s;
        u.neg     = ng;
        u.last    = lst;
        u.dst     = d;
        return u;
    endfunction

    // expansion along row 0; 2x2 minors of rows 2-3 go to slots 0..5,
    // 3x3 minors of rows 1-3 without column c go to slot 6+c
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:    u = ld (2'd2, 2'd0);
            6'd1:    u = mac(2'd3, 2'd1, 1'b1, 4'd0, 1'b0, 1'b0, 4'd0);
            6'd2:    u = ld (2'd2, 2'd1);
            6'd3:    u = mac(2'd3, 2'd0, 1'b1, 4'd0, 1'b1, 1'b1, 4'd0);
            6'd4:    u = ld (2'd2, 2'd0);
            6'd5:    u = mac(2'd3, 2'd2, 1'b1, 4'd0, 1'b0, 1'b0, 4'd0);
            6'd6:    u = ld (2'd2, 2'd2);
            6'd7:    u = mac(2'd3, 2'd0, 1'b1, 4'd0, 1'b1, 1'b1, 4'd1);
            6'd8:    u = ld (2'd2, 2'd0);
            6'd9:    u = mac(2'd3, 2'd3, 1'b1, 4'd0, 1'b0, 1'b0, 4'd0);
            6'd10:   u = ld (2'd2, 2'd3);
            6'd11:   u = mac(2'd3, 2'd0, 1'b1, 4'd0, 1'b1, 1'b1, 4'd2);
            6'd12:   u = ld (2'd2, 2'd1);
            6'd13:   u = mac(2'd3, 2'd2, 1'b1, 4'd0, 1'b0, 1'b0, 4'd0);
            6'd14:   u = ld (2'd2, 2'd2);
            6'd15:   u = mac(2'd3, 2'd1, 1'b1, 4'd0, 1'b1, 1'b1, 4'd3);
            6'd16:   u = ld (2'd2, 2'd1);
            6'd17:   u = mac(2'd3, 2'd3, 1'b1, 4'd0, 1'b0, 1'b0, 4'd0);
            6'd18:   u = ld (2'd2, 2'd3);
            6'd19:   u = mac(2'd3, 2'd1, 1'b1, 4'd0, 1'b1, 1'b1, 4'd4);
            6'd20:   u = ld (2'd2, 2'd2);
            6'd21:   u = mac(2'd3, 2'd3, 1'b1, 4'd0, 1'b0, 1'b0, 4'd0);
            6'd22:   u = ld (2'd2, 2'd3);
            6'd23:   u = mac(2'd3, 2'd2, 1'b1, 4'd0, 1'b1, 1'b1, 4'd5);
            6'd24:   u = mac(2'd1, 2'd1, 1'b0, 4'd5, 1'b0, 1'b0, 4'd0);
            6'd25:   u = mac(2'd1, 2'd2, 1'b0, 4'd4, 1'b1, 1'b0, 4'd0);
            6'd26:   u = mac(2'd1, 2'd3, 1'b0, 4'd3, 1'b0, 1'b1, 4'd6);
            6'd27:   u = mac(2'd1, 2'd0, 1'b0, 4'd5, 1'b0, 1'b0, 4'd0);
            6'd28:   u = mac(2'd1, 2'd2, 1'b0, 4'd2, 1'b1, 1'b0, 4'd0);
            6'd29:   u = mac(2'd1, 2'd3, 1'b0, 4'd1, 1'b0, 1'b1, 4'd7);
            6'd30:   u = mac(2'd1, 2'd0, 1'b0, 4'd4, 1'b0, 1'b0, 4'd0);
            6'd31:   u = mac(2'd1, 2'd1, 1'b0, 4'd2, 1'b1, 1'b0, 4'd0);
            6'd32:   u = mac(2'd1, 2'd3, 1'b0, 4'd0, 1'b0, 1'b1, 4'd8);
            6'd33:   u = mac(2'd1, 2'd0, 1'b0, 4'd3, 1'b0, 1'b0, 4'd0);
            6'd34:   u = mac(2'd1, 2'd1, 1'b0, 4'd1, 1'b1, 1'b0, 4'd0);
            6'd35:   u = mac(2'd1, 2'd2, 1'b0, 4'd0, 1'b0, 1'b1, 4'd9);
            6'd36:   u = mac(2'd0, 2'd0, 1'b0, 4'd6, 1'b0, 1'b0, 4'd0);
            6'd37:   u = mac(2'd0, 2'd1, 1'b0, 4'd7, 1'b1, 1'b0, 4'd0);
            6'd38:   u = mac(2'd0, 2'd2, 1'b0, 4'd8, 1'b0, 1'b0, 4'd0);
            6'd39:   u = mac(2'd0, 2'd3, 1'b0, 4'd9, 1'b1, 1'b0, 4'd0);
            default: u = ld (2'd0, 2'd0);
        endcase
        return u;
    endfunction

endpackage

// File: rtl/integer_determinant_4x4_core.sv
// ----------------------------------------------------------------------------
// integer_determinant_4x4_core
// program: after the last entry of a matrix, 12 operand loads (fetch, multiply) and
//   28 multiply-accumulates (fetch, multiply, accumulate) run on the one shared 15x47
//   multiplier, then the result word is captured once the output register is free
// throughput: one entry word per cycle while loading; no entries are taken meanwhile
// reset: synchronous active-low; order returns to 4, load count to zero,
//   output word dropped; matrix store contents are not cleared
// ----------------------------------------------------------------------------
module integer_determinant_4x4_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: matrix order, 1 to 4
    input  logic                          i_cfg_we,
    input  logic [idet_pkg::ORDER_W-1:0]  i_cfg_wdata,
    // entry words in row-major order
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [14:0] entry_value, [15] zero
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // [61:0] determinant, [63:62] zero
    output logic                          m_tuser    // [0] is_singular
);

    idet_pkg::t_dp_cmd                    w_cmd;
    logic                                 w_capture;
    logic                                 w_out_free;
    logic signed [idet_pkg::DET_W-1:0]    w_acc;

    logic                                 r_m_tvalid;
    logic [idet_pkg::DET_W-1:0]           r_det;
    logic                                 r_sing;

    // the output register frees up in the same cycle its word is taken
    assign w_out_free = !r_m_tvalid || m_tready;

    // sequencer: counts entries, then steps the micro-op program
    idet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .i_out_free  (w_out_free),
        .o_capture   (w_capture),
        .o_cmd       (w_cmd)
    );

    // datapath: store, multiplier-accumulator, 2x2 and 3x3 minors
    idet_dp u_dp (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_entry (s_tdata[idet_pkg::ENTRY_W-1:0]),
        .o_acc   (w_acc)
    );

    // result register, loaded from the accumulator once the program ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_capture) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_det  <= w_acc;
            r_sing <= (w_acc == '0);
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {2'b00, r_det};
    assign m_tuser  = r_sing;

endmodule

// File: rtl/idet_ctrl.sv
// ----------------------------------------------------------------------------
// idet_ctrl
// load counter, order register and micro-op sequencer
// ----------------------------------------------------------------------------
module idet_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [idet_pkg::ORDER_W-1:0]   i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_out_free,
    output logic                           o_capture,
    output idet_pkg::t_dp_cmd              o_cmd
);

    idet_pkg::t_state                r_state, n_state;
    logic [idet_pkg::PC_W-1:0]       r_pc, n_pc;
    logic [idet_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [idet_pkg::ORDER_W-1:0]    r_order;
    logic [idet_pkg::CNT_W-1:0]      r_total;
    idet_pkg::t_uop                  w_uop;
    logic                            w_accept;
    logic [idet_pkg::ORDER_W-1:0]    w_sat;

    // order zero acts as one, anything above the maximum saturates
    function automatic logic [idet_pkg::ORDER_W-1:0] sat_order(
        input logic [idet_pkg::ORDER_W-1:0] v);
        logic [idet_pkg::ORDER_W-1:0] o;
        case (v) inside
            3'd0:        o = 3'd1;
            [3'd1:3'd4]: o = v;
            default:     o = 3'(idet_pkg::MAX_ORDER);
        endcase
        return o;
    endfunction

    assign w_uop    = idet_pkg::uop_rom(r_pc);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_sat    = sat_order(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idet_pkg::ST_LOAD;
            r_pc    <= '0;
            r_cnt   <= '0;
            r_order <= 3'(idet_pkg::MAX_ORDER);
            r_total <= 5'(idet_pkg::CELLS);
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (i_cfg_we) begin
                r_order <= w_sat;
                r_total <= 5'(w_sat) * 5'(w_sat);
                r_cnt   <= '0;
            end else begin
                r_cnt   <= n_cnt;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_cnt   = r_cnt;
        case (r_state)
            idet_pkg::ST_LOAD: begin
                if (w_accept) begin
                    if (r_cnt + 5'd1 == r_total) begin
                        n_cnt   = '0;
                        n_pc    = '0;
                        n_state = idet_pkg::ST_FETCH;
                    end else begin
                        n_cnt   = r_cnt + 5'd1;
                    end
                end
            end
            idet_pkg::ST_FETCH: begin
                n_state = idet_pkg::ST_MUL;
            end
            idet_pkg::ST_MUL: begin
                if (w_uop.kind == idet_pkg::UK_LOAD) begin
                    n_pc    = r_pc + 6'd1;
                    n_state = idet_pkg::ST_FETCH;
                end else begin
                    n_state = idet_pkg::ST_ACC;
                end
            end
            idet_pkg::ST_ACC: begin
                if (r_pc == 6'(idet_pkg::PROG_LEN - 1)) begin
                    n_state = idet_pkg::ST_DONE;
                end else begin
                    n_pc    = r_pc + 6'd1;
                    n_state = idet_pkg::ST_FETCH;
                end
            end
            idet_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = idet_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = idet_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_capture     = 1'b0;
        o_cmd         = '0;
        o_cmd.ld_addr = r_cnt[idet_pkg::ADDR_W-1:0];
        o_cmd.order   = r_order;
        o_cmd.uop     = w_uop;
        case (r_state)
            idet_pkg::ST_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_en  = i_in_valid;
                o_cmd.clr    = 1'b1;
            end
            idet_pkg::ST_FETCH: o_cmd.fetch = 1'b1;
            idet_pkg::ST_MUL:   o_cmd.exec  = 1'b1;
            idet_pkg::ST_ACC:   o_cmd.accum = 1'b1;
            idet_pkg::ST_DONE:  o_capture   = i_out_free;
            default:            o_cmd.clr   = 1'b1;
        endcase
    end

endmodule

// File: rtl/idet_dp.sv
// ----------------------------------------------------------------------------
// idet_dp
// matrix store, shared multiplier-accumulator and minor scratch registers
// ----------------------------------------------------------------------------
module idet_dp (
    input  logic                                i_clk,
    input  idet_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [idet_pkg::ENTRY_W-1:0] i_entry,
    output logic signed [idet_pkg::DET_W-1:0]   o_acc
);

    logic signed [idet_pkg::ENTRY_W-1:0] r_mem [idet_pkg::CELLS];
    logic signed [idet_pkg::ENTRY_W-1:0] r_rdata;
    logic                                r_pad;
    logic                                r_pad_one;
    logic signed [idet_pkg::SCR_W-1:0]   r_opb;
    logic signed [idet_pkg::SCR_W-1:0]   r_scr [idet_pkg::SCR_DEPTH];
    logic signed [idet_pkg::DET_W-1:0]   r_prod;
    logic signed [idet_pkg::DET_W-1:0]   r_acc;

    logic [1:0]                          w_off;
    logic [1:0]                          w_r;
    logic [1:0]                          w_c;
    logic                                w_pad;
    logic [idet_pkg::ADDR_W-1:0]         w_rd_addr;
    logic signed [idet_pkg::ENTRY_W-1:0] w_ent;
    logic signed [idet_pkg::SCR_W-1:0]   w_opsel;
    logic signed [idet_pkg::DET_W-1:0]   w_ent_x;
    logic signed [idet_pkg::DET_W-1:0]   w_opsel_x;
    logic signed [idet_pkg::DET_W-1:0]   w_sum;

    function automatic logic signed [idet_pkg::SCR_W-1:0] SCR_EXT(
        input logic signed [idet_pkg::ENTRY_W-1:0] v);
        return {{(idet_pkg::SCR_W - idet_pkg::ENTRY_W){v[idet_pkg::ENTRY_W-1]}}, v};
    endfunction

    // smaller orders sit in the lower right corner, identity above-left
    assign w_off     = 2'(3'(idet_pkg::MAX_ORDER) - i_cmd.order);
    assign w_pad     = (i_cmd.uop.row < w_off) || (i_cmd.uop.col < w_off);
    assign w_r       = i_cmd.uop.row - w_off;
    assign w_c       = i_cmd.uop.col - w_off;
    assign w_rd_addr = 4'({2'b00, w_r} * {1'b0, i_cmd.order}) + {2'b00, w_c};

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_en) begin
            r_mem[i_cmd.ld_addr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_rdata   <= r_mem[w_rd_addr];
            r_pad     <= w_pad;
            r_pad_one <= (i_cmd.uop.row == i_cmd.uop.col);
        end
    end

    assign w_ent     = r_pad ? (r_pad_one ? 15'sd1 : 15'sd0) : r_rdata;
    assign w_opsel   = i_cmd.uop.use_tmp ? r_opb : r_scr[i_cmd.uop.src];
    assign w_sum     = i_cmd.uop.neg ? (r_acc - r_prod) : (r_acc + r_prod);

    // operands sign-extended to the product width
    assign w_ent_x   = {{(idet_pkg::DET_W - idet_pkg::ENTRY_W){w_ent[idet_pkg::ENTRY_W-1]}},
                        w_ent};
    assign w_opsel_x = {{(idet_pkg::DET_W - idet_pkg::SCR_W){w_opsel[idet_pkg::SCR_W-1]}},
                        w_opsel};

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (i_cmd.uop.kind == idet_pkg::UK_LOAD) begin
                r_opb  <= SCR_EXT(w_ent);
            end else begin
                r_prod <= w_ent_x * w_opsel_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_acc <= '0;
        end else if (i_cmd.accum) begin
            if (i_cmd.uop.last) begin
                r_scr[i_cmd.uop.dst] <= w_sum[idet_pkg::SCR_W-1:0];
                r_acc                <= '0;
            end else begin
                r_acc                <= w_sum;
            end
        end
    end

    assign o_acc = r_acc;

endmodule

// File: rtl/idet_checker.sv
// ----------------------------------------------------------------------------
// idet_checker
// port-level checks on the determinant core, bound to the top level
// ----------------------------------------------------------------------------
module idet_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [63:0]                   m_tdata,
    input  logic                          m_tuser
);

    // no result word right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // singular flag agrees with the determinant
    a_sing_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == (m_tdata[61:0] == 62'd0)))
        else $error("singular flag disagrees with determinant");

    // padding bits above the determinant stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[63:62] == 2'b00))
        else $error("nonzero padding in result word");

    // while computing the core takes no entries, so a result never appears
    // in the cycle right after an entry word is accepted
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result word without compute time");

endmodule

bind integer_determinant_4x4_core idet_checker u_idet_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
